// ----- rtl/core/lrx_pkg.sv -----
// Shared constants, types and coefficient address decode for the crossover.
// No dependencies; lrx_ctrl, lrx_dp and linkwitz_riley_crossover import this package.
`timescale 1ns / 1ps

package lrx_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_FRAC_DEF   = 28;
	localparam int COEF_BITS       = 32;
	localparam int NUM_REGS        = 8;
	localparam int REG_IDX_BITS    = 3;
	localparam int STAGES          = 4;
	localparam int STAGE_BITS      = 2;
	localparam int TAP_BITS        = 3;

	// register file map
	localparam logic [REG_IDX_BITS-1:0] REG_LOW_B0  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_LOW_B1  = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_LOW_B2  = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_FB_A1   = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_FB_A2   = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_HIGH_B0 = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_HIGH_B1 = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_HIGH_B2 = 3'd7;

	// multiply-accumulate taps of one biquad, in issue order
	localparam logic [TAP_BITS-1:0] TAP_X0 = 3'd0;
	localparam logic [TAP_BITS-1:0] TAP_X1 = 3'd1;
	localparam logic [TAP_BITS-1:0] TAP_X2 = 3'd2;
	localparam logic [TAP_BITS-1:0] TAP_Y1 = 3'd3;
	localparam logic [TAP_BITS-1:0] TAP_Y2 = 3'd4;

	typedef struct packed {
		logic                  ld_sample;
		logic                  issue;
		logic [STAGE_BITS-1:0] stage;
		logic [TAP_BITS-1:0]   tap;
		logic                  ld_out;
	} lrx_cmd_t;

	// band 0 is low, 1 is high; feedback taps are shared
	function automatic logic [REG_IDX_BITS-1:0] coef_index(input logic band,
			input logic [TAP_BITS-1:0] tap);
		logic [REG_IDX_BITS-1:0] idx;
		idx = REG_LOW_B0;
		unique case (tap)
			TAP_X0: idx = band ? REG_HIGH_B0 : REG_LOW_B0;
			TAP_X1: idx = band ? REG_HIGH_B1 : REG_LOW_B1;
			TAP_X2: idx = band ? REG_HIGH_B2 : REG_LOW_B2;
			TAP_Y1: idx = REG_FB_A1;
			TAP_Y2: idx = REG_FB_A2;
			default: idx = REG_LOW_B0;
		endcase
		return idx;
	endfunction

endpackage

// ----- rtl/core/lrx_sample_if.sv -----
// Input word channel: valid/ready handshake plus one audio sample.
// Standalone; width follows the SAMPLE_BITS parameter of the instance.
`timescale 1ns / 1ps

interface lrx_sample_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/core/lrx_band_if.sv -----
// Output word channel: valid/ready handshake plus low and high band samples.
// Standalone; width follows the SAMPLE_BITS parameter of the instance.
`timescale 1ns / 1ps

interface lrx_band_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] low_band;
	logic signed [SAMPLE_BITS-1:0] high_band;

	modport source (output valid, output low_band, output high_band, input ready);
	modport sink   (input valid, input low_band, input high_band, output ready);
endinterface

// ----- rtl/core/lrx_ctrl.sv -----
// Sequencer for the crossover: handshakes and the 20-step MAC schedule.
// Depends on lrx_pkg; drives lrx_dp through an lrx_cmd_t bundle.
`timescale 1ns / 1ps

module lrx_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output lrx_pkg::lrx_cmd_t cmd
);
	import lrx_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [STAGE_BITS-1:0] LAST_STAGE = STAGE_BITS'(STAGES - 1);

	logic [1:0]            state_q;
	logic [STAGE_BITS-1:0] stage_q;
	logic [TAP_BITS-1:0]   tap_q;
	logic                  out_valid_q;
	logic                  load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.ld_sample = in_valid && in_ready;
		cmd.issue     = (state_q == ST_RUN);
		cmd.stage     = stage_q;
		cmd.tap       = tap_q;
		cmd.ld_out    = load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_q     <= '0;
			tap_q       <= TAP_X0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						stage_q <= '0;
						tap_q   <= TAP_X0;
					end
				end
				ST_RUN: begin
					if (tap_q == TAP_Y2) begin
						tap_q <= TAP_X0;
						if (stage_q == LAST_STAGE)
							state_q <= ST_FLUSH;
						else
							stage_q <= stage_q + 1'b1;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_FLUSH: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/lrx_dp.sv -----
// Datapath for the crossover: coefficient registers, biquad histories,
// one shared multiplier, accumulator with round/saturate. Depends on lrx_pkg.
`timescale 1ns / 1ps

module lrx_dp #(
	parameter int SAMPLE_BITS    = lrx_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = lrx_pkg::COEF_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [lrx_pkg::REG_IDX_BITS-1:0]     wr_index,
	input  logic [lrx_pkg::COEF_BITS-1:0]        wr_data,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	input  lrx_pkg::lrx_cmd_t                    cmd,
	output logic signed [SAMPLE_BITS-1:0]        low_band,
	output logic signed [SAMPLE_BITS-1:0]        high_band
);
	import lrx_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W  = PROD_W + 3;
	localparam int OUT_W  = ACC_W - COEF_FRAC_BITS;

	localparam logic signed [ACC_W-1:0] RND =
		{{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] SMAX =
		{{(OUT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SMIN =
		{{(OUT_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x1;
		logic signed [SAMPLE_BITS-1:0] x2;
		logic signed [SAMPLE_BITS-1:0] y1;
		logic signed [SAMPLE_BITS-1:0] y2;
	} hist_t;

	logic signed [COEF_BITS-1:0]   coef_q [NUM_REGS];
	hist_t                         hist_q [STAGES];
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] low_q, high_q;

	logic signed [PROD_W-1:0]      product_s1;
	logic                          vld_s1, first_s1, last_s1;
	logic [STAGE_BITS-1:0]         stage_s1;
	logic signed [ACC_W-1:0]       acc_q;

	logic signed [SAMPLE_BITS-1:0] issue_x, fin_x, operand;
	logic signed [COEF_BITS-1:0]   coef_sel;
	logic signed [ACC_W-1:0]       sum_fin;
	logic signed [OUT_W-1:0]       y_wide;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	// stage input: first stages see the sample, second stages the first's output
	function automatic logic signed [SAMPLE_BITS-1:0] stage_in(
			input logic [STAGE_BITS-1:0] s, input hist_t h0, input hist_t h1,
			input logic signed [SAMPLE_BITS-1:0] x);
		logic signed [SAMPLE_BITS-1:0] v;
		v = x;
		if (s[1])
			v = s[0] ? h1.y1 : h0.y1;
		return v;
	endfunction

	assign issue_x = stage_in(cmd.stage, hist_q[0], hist_q[1], x_q);
	assign fin_x   = stage_in(stage_s1, hist_q[0], hist_q[1], x_q);

	always_comb begin
		coef_sel = coef_q[coef_index(cmd.stage[0], cmd.tap)];
		case (cmd.tap)
			TAP_X0:  operand = issue_x;
			TAP_X1:  operand = hist_q[cmd.stage].x1;
			TAP_X2:  operand = hist_q[cmd.stage].x2;
			TAP_Y1:  operand = hist_q[cmd.stage].y1;
			TAP_Y2:  operand = hist_q[cmd.stage].y2;
			default: operand = '0;
		endcase
	end

	// last product closes the sum: round half up, floor shift, saturate
	always_comb begin
		sum_fin = acc_q + ACC_W'(product_s1) + RND;
		y_wide  = sum_fin[ACC_W-1:COEF_FRAC_BITS];
		if (y_wide > SMAX)
			y_sat = SMAX[SAMPLE_BITS-1:0];
		else if (y_wide < SMIN)
			y_sat = SMIN[SAMPLE_BITS-1:0];
		else
			y_sat = y_wide[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				coef_q[i] <= '0;
			for (int s = 0; s < STAGES; s++)
				hist_q[s] <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en)
				coef_q[wr_index] <= wr_data;
			vld_s1 <= cmd.issue;
			if (vld_s1 && last_s1) begin
				hist_q[stage_s1].x1 <= fin_x;
				hist_q[stage_s1].x2 <= hist_q[stage_s1].x1;
				hist_q[stage_s1].y1 <= y_sat;
				hist_q[stage_s1].y2 <= hist_q[stage_s1].y1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_sample)
			x_q <= sample_in;
		product_s1 <= coef_sel * operand;
		first_s1   <= (cmd.tap == TAP_X0);
		last_s1    <= (cmd.tap == TAP_Y2);
		stage_s1   <= cmd.stage;
		if (vld_s1 && !last_s1)
			acc_q <= (first_s1 ? '0 : acc_q) + ACC_W'(product_s1);
		if (cmd.ld_out) begin
			low_q  <= hist_q[2].y1;
			high_q <= hist_q[3].y1;
		end
	end

	assign low_band  = low_q;
	assign high_band = high_q;

endmodule

// ----- rtl/core/linkwitz_riley_crossover.sv -----
// Top level of the fourth-order Linkwitz-Riley crossover.
// Depends on lrx_pkg, lrx_sample_if, lrx_band_if, lrx_ctrl and lrx_dp.
`timescale 1ns / 1ps

// One input word (a signed Q1.23 sample) yields one output word holding the
// low band and the high band, each after two cascaded direct-form-I biquads
// with Q4.28 coefficients. All twenty multiply-accumulates of a sample run
// through a single 32 x SAMPLE_BITS multiplier, so a sample is accepted, its
// MAC issues run in order (low first stage, high first stage, low second,
// high second), the product register drains and the output register loads
// before the next sample can be taken. The output register lets a result
// wait for the sink; the next sample is then accepted at once, and its
// result is held back only if the previous word still sits unread when its
// computation ends. Coefficients are written through wr_en/wr_index/wr_data
// (indexes 0..7: low_b0, low_b1, low_b2, fb_a1, fb_a2, high_b0, high_b1,
// high_b2); the user writes them only while no sample is in flight, and the
// block does not enforce this. fb_a1 and fb_a2 are stored negated and are
// shared by both bands. Reset zeroes the coefficients and all filter history.

module linkwitz_riley_crossover #(
	parameter int SAMPLE_BITS    = lrx_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = lrx_pkg::COEF_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [lrx_pkg::REG_IDX_BITS-1:0] wr_index,
	input  logic [lrx_pkg::COEF_BITS-1:0]    wr_data,
	lrx_sample_if.sink                       din,
	lrx_band_if.source                       dout
);
	import lrx_pkg::*;

	lrx_cmd_t cmd;

	// sequencer: owns both handshakes and the MAC schedule
	lrx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.cmd       (cmd)
	);

	// arithmetic, coefficient registers, histories and the output word
	lrx_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.sample_in (din.sample_in),
		.cmd       (cmd),
		.low_band  (dout.low_band),
		.high_band (dout.high_band)
	);

endmodule
